>>> rtl/core/dlr_pkg.sv
// ----------------------------------------------------------------------------
// dlr_pkg
// Shared constants, codes and controller/datapath types of the line rasterizer.
// ----------------------------------------------------------------------------
package dlr_pkg;

    // Default geometry of the datapath.
    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 16;

    // Configuration registers.
    localparam int REG_BITS   = 13;
    localparam int CFG_ADDR_W = 1;

    localparam logic [CFG_ADDR_W-1:0] CFG_TEX_WIDTH  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_TEX_HEIGHT = 1'b1;

    localparam logic [REG_BITS-1:0] TEX_WIDTH_RST  = 13'd640;
    localparam logic [REG_BITS-1:0] TEX_HEIGHT_RST = 13'd480;

    // Item opcodes.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    // Result fields.
    localparam int INDEX_BITS = 24;
    localparam int COLOR_BITS = 32;

    localparam logic [COLOR_BITS-1:0] COLOR_Y_MAJOR = 32'hFF00_00FF;
    localparam logic [COLOR_BITS-1:0] COLOR_X_MAJOR = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACTIVE,
        ST_DIV
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture endpoints and start the slope division
        logic step;    // advance the line by one pixel
        logic commit;  // take the finished quotient as the new slope
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic stall;          // result register is full and not being taken
        logic div_done;       // quotient is valid this cycle
        logic line_nonempty;  // the loaded line has at least one pixel
        logic step_last;      // the next step is the final pixel of the line
    } t_dp_status;

endpackage

>>> rtl/core/dlr_item_if.sv
// ----------------------------------------------------------------------------
// dlr_item_if
// Input channel: load and step items with valid/ready handshake.
// ----------------------------------------------------------------------------
interface dlr_item_if #(
    parameter int COORD_BITS = dlr_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         op;
    logic signed [COORD_BITS-1:0] x_start;
    logic signed [COORD_BITS-1:0] y_start;
    logic signed [COORD_BITS-1:0] x_end;
    logic signed [COORD_BITS-1:0] y_end;

    modport source (
        output valid, op, x_start, y_start, x_end, y_end,
        input  ready
    );

    modport sink (
        input  valid, op, x_start, y_start, x_end, y_end,
        output ready
    );
endinterface

>>> rtl/core/dlr_pixel_if.sv
// ----------------------------------------------------------------------------
// dlr_pixel_if
// Output channel: one pixel write per beat with valid/ready handshake.
// ----------------------------------------------------------------------------
interface dlr_pixel_if;
    logic                            valid;
    logic                            ready;
    logic [dlr_pkg::INDEX_BITS-1:0]  pixel_index;
    logic                            write_enable;
    logic [dlr_pkg::COLOR_BITS-1:0]  rgba_color;
    logic                            last_step;

    modport source (
        output valid, pixel_index, write_enable, rgba_color, last_step,
        input  ready
    );

    modport sink (
        input  valid, pixel_index, write_enable, rgba_color, last_step,
        output ready
    );
endinterface

>>> rtl/core/dlr_divider.sv
// ----------------------------------------------------------------------------
// dlr_divider
// Restoring divider, one quotient bit per cycle: (num << FRAC_BITS) / den.
// ----------------------------------------------------------------------------
module dlr_divider #(
    parameter int COORD_BITS = dlr_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = dlr_pkg::FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [COORD_BITS-1:0] i_num,
    input  logic [COORD_BITS-1:0] i_den,
    output logic [FRAC_BITS:0]    o_quo,
    output logic                  o_done
);
    localparam int DVD_W = COORD_BITS + FRAC_BITS;
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [COORD_BITS-1:0] r_rem;
    logic [COORD_BITS-1:0] r_den;
    logic [DVD_W-1:0]      r_quo;

    logic [COORD_BITS:0]   trial;
    logic [COORD_BITS:0]   diff;
    logic                  fits;
    logic [COORD_BITS-1:0] n_rem;

    // The remainder stays below the divisor, so one extra bit holds the trial.
    assign trial = {r_rem, r_quo[DVD_W-1]};
    assign diff  = trial - {1'b0, r_den};
    assign fits  = trial >= {1'b0, r_den};
    assign n_rem = fits ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_den;
            r_quo <= {i_num, {FRAC_BITS{1'b0}}};
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[DVD_W-2:0], fits};
        end
    end

    // The quotient never exceeds 1 << FRAC_BITS since |num| <= |den|.
    assign o_quo  = r_quo[FRAC_BITS:0];
    assign o_done = r_done;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider finished without running");

endmodule

>>> rtl/core/dlr_ctrl.sv
// ----------------------------------------------------------------------------
// dlr_ctrl
// Controller: takes items, sequences the slope division and tracks the line.
// ----------------------------------------------------------------------------
module dlr_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_op,
    output logic                o_in_ready,
    input  dlr_pkg::t_dp_status i_status,
    output dlr_pkg::t_dp_cmd    o_cmd
);
    import dlr_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                // Steps with no line are taken and dropped.
                o_in_ready = !i_status.stall;
                if (i_in_valid && o_in_ready && i_in_op == OP_LOAD) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DIV;
                end
            end
            ST_ACTIVE: begin
                o_in_ready = !i_status.stall;
                if (i_in_valid && o_in_ready) begin
                    if (i_in_op == OP_LOAD) begin
                        o_cmd.load = 1'b1;
                        n_state    = ST_DIV;
                    end else begin
                        o_cmd.step = 1'b1;
                        if (i_status.step_last) begin
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            ST_DIV: begin
                if (i_status.div_done) begin
                    o_cmd.commit = 1'b1;
                    n_state      = i_status.line_nonempty ? ST_ACTIVE : ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    a_step_only_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.step |-> r_state == ST_ACTIVE)
        else $error("step issued with no active line");

    a_no_take_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIV |-> !o_in_ready)
        else $error("item taken during slope division");

    a_commit_leaves_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> (r_state == ST_ACTIVE || r_state == ST_IDLE))
        else $error("controller stayed in division after commit");

endmodule

>>> rtl/core/dlr_datapath.sv
// ----------------------------------------------------------------------------
// dlr_datapath
// Line setup, slope and accumulator registers, and the pixel index pipeline.
// ----------------------------------------------------------------------------
module dlr_datapath #(
    parameter int COORD_BITS = dlr_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = dlr_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [dlr_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [dlr_pkg::REG_BITS-1:0]        i_cfg_data,
    input  logic signed [COORD_BITS-1:0]        i_x_start,
    input  logic signed [COORD_BITS-1:0]        i_y_start,
    input  logic signed [COORD_BITS-1:0]        i_x_end,
    input  logic signed [COORD_BITS-1:0]        i_y_end,
    input  dlr_pkg::t_dp_cmd                    i_cmd,
    output dlr_pkg::t_dp_status                 o_status,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [dlr_pkg::INDEX_BITS-1:0]      o_pixel_index,
    output logic                                o_write_enable,
    output logic [dlr_pkg::COLOR_BITS-1:0]      o_rgba_color,
    output logic                                o_last_step
);
    import dlr_pkg::*;

    localparam int C      = COORD_BITS;
    localparam int A_W    = COORD_BITS + FRAC_BITS;
    localparam int S_W    = FRAC_BITS + 2;
    localparam int PROD_W = COORD_BITS - 1 + REG_BITS;
    localparam int IDX_W  = COORD_BITS + REG_BITS;
    localparam int AREA_W = 2 * REG_BITS;
    localparam int CMP_W  = (IDX_W > AREA_W) ? IDX_W : AREA_W;

    localparam logic signed [S_W-1:0] SLOPE_ONE = S_W'(1) << FRAC_BITS;

    // ------------------------------------------------------------------
    // Configuration registers and texture area
    // ------------------------------------------------------------------
    logic [REG_BITS-1:0] r_tex_width;
    logic [REG_BITS-1:0] r_tex_height;
    logic [AREA_W-1:0]   r_area;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_width  <= TEX_WIDTH_RST;
            r_tex_height <= TEX_HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_TEX_WIDTH:  r_tex_width  <= i_cfg_data;
                CFG_TEX_HEIGHT: r_tex_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_area <= AREA_W'(r_tex_width) * AREA_W'(r_tex_height);
    end

    // ------------------------------------------------------------------
    // Line setup
    // ------------------------------------------------------------------
    logic signed [C:0]   dx;
    logic signed [C:0]   dy;
    logic [C:0]          adx_full;
    logic [C:0]          ady_full;
    logic [C-1:0]        adx;
    logic [C-1:0]        ady;
    logic                major_y;
    logic [C-1:0]        num_mag;
    logic [C-1:0]        den_mag;
    logic                quo_neg;
    logic signed [C-1:0] src_major;
    logic signed [C-1:0] dst_major;
    logic signed [C-1:0] src_minor;

    assign dx       = {i_x_end[C-1], i_x_end} - {i_x_start[C-1], i_x_start};
    assign dy       = {i_y_end[C-1], i_y_end} - {i_y_start[C-1], i_y_start};
    assign adx_full = dx[C] ? -dx : dx;
    assign ady_full = dy[C] ? -dy : dy;
    assign adx      = adx_full[C-1:0];
    assign ady      = ady_full[C-1:0];
    assign major_y  = ady > adx;

    always_comb begin
        if (major_y) begin
            num_mag = adx;
            den_mag = ady;
            quo_neg = dx[C] ^ dy[C];
            if (i_y_start < i_y_end) begin
                src_major = i_y_start;
                dst_major = i_y_end;
                src_minor = i_x_start;
            end else begin
                src_major = i_y_end;
                dst_major = i_y_start;
                src_minor = i_x_end;
            end
        end else begin
            num_mag = ady;
            den_mag = adx;
            quo_neg = dx[C] ^ dy[C];
            if (i_x_start < i_x_end) begin
                src_major = i_x_start;
                dst_major = i_x_end;
                src_minor = i_y_start;
            end else begin
                src_major = i_x_end;
                dst_major = i_x_start;
                src_minor = i_y_end;
            end
        end
    end

    // ------------------------------------------------------------------
    // Slope division
    // ------------------------------------------------------------------
    logic [FRAC_BITS:0] quo;
    logic               div_done;

    dlr_divider #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.load),
        .i_num   (num_mag),
        .i_den   (den_mag),
        .o_quo   (quo),
        .o_done  (div_done)
    );

    // ------------------------------------------------------------------
    // Line state
    // ------------------------------------------------------------------
    logic                  r_major_is_y;
    logic signed [C-1:0]   r_major_coord;
    logic signed [C-1:0]   r_major_end;
    logic signed [A_W-1:0] r_accum;
    logic signed [S_W-1:0] r_slope;
    logic                  r_quo_neg;
    logic                  r_den_zero;
    logic                  r_nonempty;

    logic signed [A_W-1:0] accum_sum;
    logic signed [C:0]     coord_inc;
    logic signed [S_W-1:0] quo_ext;
    logic                  step_last;

    assign accum_sum = r_accum + {{(A_W-S_W){r_slope[S_W-1]}}, r_slope};
    assign coord_inc = {r_major_coord[C-1], r_major_coord} + 1'b1;
    assign step_last = coord_inc >= $signed({r_major_end[C-1], r_major_end});
    assign quo_ext   = {1'b0, quo};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_major_is_y <= 1'b0;
        end else if (i_cmd.load) begin
            r_major_is_y <= major_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_major_coord <= src_major;
            r_major_end   <= dst_major;
            r_accum       <= {src_minor, {FRAC_BITS{1'b0}}};
            r_quo_neg     <= quo_neg;
            r_den_zero    <= den_mag == '0;
            r_nonempty    <= src_major < dst_major;
        end else if (i_cmd.step) begin
            r_major_coord <= coord_inc[C-1:0];
            r_accum       <= accum_sum;
        end
        if (i_cmd.commit) begin
            if (r_den_zero) begin
                r_slope <= '0;
            end else begin
                r_slope <= r_quo_neg ? -quo_ext : quo_ext;
            end
        end
    end

    // ------------------------------------------------------------------
    // Pixel pipeline: truncate, multiply, add and bounds test, result
    // ------------------------------------------------------------------
    logic stall;
    logic advance;

    logic                  r_s1_v;
    logic signed [A_W-1:0] r_s1_accum;
    logic signed [C-1:0]   r_s1_major;
    logic                  r_s1_is_y;
    logic                  r_s1_last;

    logic                  r_s2_v;
    logic [C-2:0]          r_s2_pym1;
    logic [C-2:0]          r_s2_px;
    logic                  r_s2_is_y;
    logic                  r_s2_last;

    logic                  r_s3_v;
    logic [PROD_W-1:0]     r_s3_prod;
    logic [C-2:0]          r_s3_px;
    logic                  r_s3_is_y;
    logic                  r_s3_last;

    logic                  r_out_v;
    logic [INDEX_BITS-1:0] r_out_index;
    logic                  r_out_we;
    logic [COLOR_BITS-1:0] r_out_color;
    logic                  r_out_last;

    logic signed [C-1:0]   minor;
    logic signed [C-1:0]   px;
    logic signed [C-1:0]   py;
    logic                  any_neg;
    logic                  py_zero;
    logic [C-2:0]          n_s2_pym1;
    logic [C-2:0]          n_s2_px;
    logic [PROD_W-1:0]     prod;
    logic [IDX_W-1:0]      idx;
    logic [CMP_W-1:0]      idx_wide;
    logic                  idx_we;

    assign stall   = r_out_v && !i_out_ready;
    assign advance = !stall;

    // Truncation toward zero: floor, then one up for a negative value that
    // has a fraction.
    assign minor = r_s1_accum[A_W-1:FRAC_BITS]
                 + C'(r_s1_accum[A_W-1] && (|r_s1_accum[FRAC_BITS-1:0]));
    assign px      = r_s1_is_y ? minor : r_s1_major;
    assign py      = r_s1_is_y ? r_s1_major : minor;
    assign any_neg = px[C-1] || py[C-1];
    assign py_zero = py == '0;

    // Operands are zeroed here so the later stages need no case split.
    assign n_s2_pym1 = (any_neg || py_zero) ? '0 : (py[C-2:0] - 1'b1);
    assign n_s2_px   = any_neg ? '0 : px[C-2:0];

    assign prod     = PROD_W'(r_s2_pym1) * PROD_W'(r_tex_width);
    assign idx      = IDX_W'(r_s3_prod) + IDX_W'(r_s3_px);
    assign idx_wide = CMP_W'(idx);
    assign idx_we   = (idx != '0) && (idx_wide < CMP_W'(r_area));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (advance) begin
            r_s1_v  <= i_cmd.step;
            r_s2_v  <= r_s1_v;
            r_s3_v  <= r_s2_v;
            r_out_v <= r_s3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_accum  <= accum_sum;
            r_s1_major  <= r_major_coord;
            r_s1_is_y   <= r_major_is_y;
            r_s1_last   <= step_last;

            r_s2_pym1   <= n_s2_pym1;
            r_s2_px     <= n_s2_px;
            r_s2_is_y   <= r_s1_is_y;
            r_s2_last   <= r_s1_last;

            r_s3_prod   <= prod;
            r_s3_px     <= r_s2_px;
            r_s3_is_y   <= r_s2_is_y;
            r_s3_last   <= r_s2_last;

            r_out_index <= idx_wide[INDEX_BITS-1:0];
            r_out_we    <= idx_we;
            r_out_color <= r_s3_is_y ? COLOR_Y_MAJOR : COLOR_X_MAJOR;
            r_out_last  <= r_s3_last;
        end
    end

    assign o_out_valid    = r_out_v;
    assign o_pixel_index  = r_out_index;
    assign o_write_enable = r_out_we;
    assign o_rgba_color   = r_out_color;
    assign o_last_step    = r_out_last;

    assign o_status.stall         = stall;
    assign o_status.div_done      = div_done;
    assign o_status.line_nonempty = r_nonempty;
    assign o_status.step_last     = step_last;

    a_slope_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> (r_slope <= SLOPE_ONE && r_slope >= -SLOPE_ONE))
        else $error("slope magnitude exceeds one pixel per step");

    a_pipe_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stall |=> ($stable(r_s1_v) && $stable(r_s2_v) && $stable(r_s3_v)))
        else $error("pixel pipeline moved while the result was stalled");

endmodule

>>> rtl/core/dda_line_rasterizer.sv
// ----------------------------------------------------------------------------
// dda_line_rasterizer
// DDA line rasterizer: loads a line, then emits one pixel write per step.
// ----------------------------------------------------------------------------
//
// Channel    Dir  Beat content
// ---------  ---  -----------------------------------------------------------
// i_item     in   op, x_start, y_start, x_end, y_end (load or step)
// o_pixel    out  pixel_index, write_enable, rgba_color, last_step
// i_cfg_*    in   register write: tex_width (index 0), tex_height (index 1)
//
// A step item is taken every cycle while a line is active and the result is
// not stalled; its pixel passes the registers in order: summed accumulator,
// truncate, multiply, then add with the bounds test, on to the result port.
// A load item blocks the input while the one-bit-per-cycle slope divider
// runs and until its quotient is committed as the slope.
// Reset is synchronous and active low; it clears the controller and the
// pipeline valid bits and restores the texture size to 640 x 480.
// A stalled result holds the whole pixel pipeline and the input.
//
// ----------------------------------------------------------------------------
module dda_line_rasterizer #(
    parameter int COORD_BITS = dlr_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = dlr_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    dlr_item_if.sink                       i_item,
    dlr_pixel_if.source                    o_pixel,
    input  logic                           i_cfg_we,
    input  logic [dlr_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [dlr_pkg::REG_BITS-1:0]   i_cfg_data
);
    import dlr_pkg::*;

    // The controller decides which beats are taken and when a division is
    // running; the datapath holds every value and reports what the
    // controller needs to make those decisions.
    t_dp_cmd    cmd;
    t_dp_status status;
    logic       in_ready;

    dlr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .i_in_op    (i_item.op),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // The datapath sets up the line on a load (axis choice, endpoint order,
    // slope division), adds the slope on each step, and turns the pixel
    // coordinates into a linear index with a bounds check against the
    // texture area. The index is zero when either coordinate is negative,
    // equal to x on the first row band, and (y - 1) * width + x otherwise.
    dlr_datapath #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_data     (i_cfg_data),
        .i_x_start      (i_item.x_start),
        .i_y_start      (i_item.y_start),
        .i_x_end        (i_item.x_end),
        .i_y_end        (i_item.y_end),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_out_ready    (o_pixel.ready),
        .o_out_valid    (o_pixel.valid),
        .o_pixel_index  (o_pixel.pixel_index),
        .o_write_enable (o_pixel.write_enable),
        .o_rgba_color   (o_pixel.rgba_color),
        .o_last_step    (o_pixel.last_step)
    );

    // Steps that arrive with no active line are taken and dropped, so the
    // input waits on them only while the result is stalled.
    assign i_item.ready = in_ready;

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the DDA line rasterizer. A short table of directed
// load and step beats runs first, then constrained-random line sequences over
// several texture sizes. Every pixel beat is checked against a typed row or a
// cycle-free model of the rasterizer kept inside the bench.
// ----------------------------------------------------------------------------
module testbench;
    import dlr_pkg::*;

    localparam int COORD         = COORD_BITS_DEF;
    localparam int FRAC          = FRAC_BITS_DEF;
    localparam int COORD_MAX     = (1 << (COORD - 1)) - 1;
    localparam int COORD_MIN     = -(1 << (COORD - 1));
    // The wait outlasts a slope division that holds the input plus the pixel
    // pipeline after it, so this covers any work still in flight.
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 400000;

    // One input beat, laid out the way the item channel carries it.
    typedef struct packed {
        logic                    op;
        logic signed [COORD-1:0] xs;
        logic signed [COORD-1:0] ys;
        logic signed [COORD-1:0] xe;
        logic signed [COORD-1:0] ye;
    } t_line_item;

    // One pixel beat as it leaves the block.
    typedef struct packed {
        logic [INDEX_BITS-1:0] index;
        logic                  we;
        logic [COLOR_BITS-1:0] color;
        logic                  last;
    } t_pixel;

    // A row of the directed table. When typed is set, the pixel in want is
    // the one the row must produce; otherwise the line model decides.
    typedef struct {
        t_line_item item;
        bit         typed;
        t_pixel     want;
    } t_plan_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [REG_BITS-1:0]   cfg_data;

    dlr_item_if #(.COORD_BITS(COORD)) item_ch ();
    dlr_pixel_if                      pixel_ch ();

    dda_line_rasterizer u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item_ch),
        .o_pixel    (pixel_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_addr (cfg_addr),
        .i_cfg_data (cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Line model: the bench's own copy of the rasterizer state and of the
    // texture size registers.
    // ------------------------------------------------------------------------
    bit                  line_on    = 1'b0;
    bit                  major_y    = 1'b0;
    logic signed [12:0]  major_pos  = '0;
    logic signed [12:0]  major_stop = '0;
    logic signed [31:0]  minor_acc  = '0;
    logic signed [31:0]  minor_step = '0;
    logic [REG_BITS-1:0] tex_w      = TEX_WIDTH_RST;
    logic [REG_BITS-1:0] tex_h      = TEX_HEIGHT_RST;

    t_pixel pending_pixels[$];
    int     error_count = 0;
    int     cycle_count = 0;
    // While calm is set neither side of the block idles.
    bit     calm = 1'b0;

    // Applies one accepted beat to the line model. Returns 1 and the pixel
    // when the beat produces one.
    function automatic bit rasterize_item(input t_line_item it, output t_pixel px);
        int     xs, ys, xe, ye, dx, dy, adx, ady;
        int     num, den, src, dst, src_minor, minor, col, row;
        longint idx, area, quot;
        bit     last;
        px = '0;
        if (it.op == OP_LOAD) begin
            xs = it.xs;
            ys = it.ys;
            xe = it.xe;
            ye = it.ye;
            dx = xe - xs;
            dy = ye - ys;
            adx = (dx < 0) ? -dx : dx;
            ady = (dy < 0) ? -dy : dy;
            // Ties go to the X axis.
            major_y = ady > adx;
            if (major_y) begin
                num = dx;
                den = dy;
                if (ys < ye) begin
                    src = ys; dst = ye; src_minor = xs;
                end else begin
                    src = ye; dst = ys; src_minor = xe;
                end
            end else begin
                num = dy;
                den = dx;
                if (xs < xe) begin
                    src = xs; dst = xe; src_minor = ys;
                end else begin
                    src = xe; dst = xs; src_minor = ye;
                end
            end
            // Signed division truncates toward zero, as the slope must.
            if (den == 0) begin
                quot = 0;
            end else begin
                quot = (longint'(num) <<< FRAC) / den;
            end
            minor_step = quot[31:0];
            major_pos  = 13'(src);
            major_stop = 13'(dst);
            minor_acc  = src_minor <<< FRAC;
            // A zero-length line never becomes active.
            line_on    = src < dst;
            return 1'b0;
        end
        if (!line_on) begin
            return 1'b0;
        end
        // The slope goes in before the pixel is formed.
        minor_acc = minor_acc + minor_step;
        if (minor_acc < 0) begin
            minor = -((-minor_acc) >>> FRAC);
        end else begin
            minor = minor_acc >>> FRAC;
        end
        if (major_y) begin
            row = major_pos;
            col = minor;
        end else begin
            col = major_pos;
            row = minor;
        end
        if (col < 0 || row < 0) begin
            idx = 0;
        end else if (row < 1) begin
            idx = col;
        end else begin
            idx = longint'(row - 1) * longint'(tex_w) + col;
        end
        area = longint'(tex_w) * longint'(tex_h);
        last = (major_pos + 1) >= major_stop;
        major_pos = 13'(major_pos + 1);
        if (last) begin
            line_on = 1'b0;
        end
        px.index = idx[INDEX_BITS-1:0];
        // The bounds test sees the full index, not the masked one.
        px.we    = (idx > 0) && (idx < area);
        px.color = major_y ? COLOR_Y_MAJOR : COLOR_X_MAJOR;
        px.last  = last;
        return 1'b1;
    endfunction

    task automatic flag_error(input string msg);
        error_count++;
        $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------------
    // Item driver. Fields change only at a rising edge; the handshake is
    // sampled on the falling edge, where nothing the bench drives can move.
    // ------------------------------------------------------------------------
    task automatic send_item(input t_line_item it, input bit typed, input t_pixel want,
                             output bit useful);
        t_pixel px;
        bit     made;
        while (!calm && $urandom_range(99) < 36) begin
            item_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.op      <= it.op;
        item_ch.x_start <= it.xs;
        item_ch.y_start <= it.ys;
        item_ch.x_end   <= it.xe;
        item_ch.y_end   <= it.ye;
        forever begin
            @(negedge i_clk);
            if (item_ch.ready) break;
            @(posedge i_clk);
        end
        // The beat is taken at the coming edge; the model moves now.
        made = rasterize_item(it, px);
        if (typed) begin
            pending_pixels.push_back(want);
        end else if (made) begin
            pending_pixels.push_back(px);
        end
        // Steps that find no line are ignored by the block and do not count.
        useful = (it.op == OP_LOAD) || made;
        @(posedge i_clk);
    endtask

    // Holds the input until every expected pixel has come back, then lets
    // a possible division or a dropped step run out of the pipeline.
    task automatic drain_pipeline();
        item_ch.valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Texture size writes happen only with the block idle.
    task automatic set_texture(input logic [REG_BITS-1:0] w, input logic [REG_BITS-1:0] h);
        drain_pipeline();
        cfg_we   <= 1'b1;
        cfg_addr <= CFG_TEX_WIDTH;
        cfg_data <= w;
        @(posedge i_clk);
        cfg_addr <= CFG_TEX_HEIGHT;
        cfg_data <= h;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        tex_w = w;
        tex_h = h;
    endtask

    function automatic logic signed [COORD-1:0] clip_coord(input int v);
        int c;
        c = (v > COORD_MAX) ? COORD_MAX : ((v < COORD_MIN) ? COORD_MIN : v);
        return c[COORD-1:0];
    endfunction

    function automatic int rand_offset(input int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    // ------------------------------------------------------------------------
    // Random traffic: mostly a load followed by the steps that walk its line,
    // with a little noise. Lines land near the origin, near the texture edge,
    // or anywhere in the coordinate space; long lines are cut short by the
    // next load so the run stays quick.
    // ------------------------------------------------------------------------
    task automatic run_lines(input int quota);
        int         done, mode, base_x, base_y, span, len, adx, ady, n_steps, k;
        t_line_item it;
        t_pixel     none;
        bit         useful;
        done = 0;
        none = '0;
        while (done < quota) begin
            if ($urandom_range(99) < 8) begin
                it.op = 1'($urandom_range(1));
                it.xs = COORD'($urandom);
                it.ys = COORD'($urandom);
                it.xe = COORD'($urandom);
                it.ye = COORD'($urandom);
                send_item(it, 1'b0, none, useful);
                done += useful;
            end else begin
                mode = $urandom_range(99);
                if (mode < 80) begin
                    if (mode < 50) begin
                        base_x = rand_offset(40) + 32;
                        base_y = rand_offset(40) + 32;
                        span   = 24;
                    end else begin
                        // Around the far corner, where write enable flips.
                        base_x = int'(tex_w) + rand_offset(6);
                        base_y = int'(tex_h) + rand_offset(6);
                        span   = 12;
                    end
                    it.xs = clip_coord(base_x);
                    it.ys = clip_coord(base_y);
                    it.xe = clip_coord(base_x + rand_offset(span));
                    it.ye = clip_coord(base_y + rand_offset(span));
                end else begin
                    it.xs = COORD'($urandom);
                    it.ys = COORD'($urandom);
                    it.xe = COORD'($urandom);
                    it.ye = COORD'($urandom);
                end
                it.op = OP_LOAD;
                send_item(it, 1'b0, none, useful);
                done += useful;
                adx = int'(it.xe) - int'(it.xs);
                ady = int'(it.ye) - int'(it.ys);
                adx = (adx < 0) ? -adx : adx;
                ady = (ady < 0) ? -ady : ady;
                len = (adx > ady) ? adx : ady;
                if (len > 40) begin
                    n_steps = $urandom_range(40, 1);
                end else if ($urandom_range(9) == 0) begin
                    n_steps = $urandom_range(len, 0);
                end else begin
                    // A couple of extra steps probe the idle case.
                    n_steps = len + $urandom_range(2);
                end
                for (k = 0; k < n_steps; k++) begin
                    it.op = OP_STEP;
                    it.xs = COORD'($urandom);
                    it.ys = COORD'($urandom);
                    it.xe = COORD'($urandom);
                    it.ye = COORD'($urandom);
                    send_item(it, 1'b0, none, useful);
                    done += useful;
                end
            end
        end
    endtask

    function automatic t_plan_row load_row(input int xs, input int ys, input int xe,
                                           input int ye);
        t_plan_row r;
        r.item    = '0;
        r.item.op = OP_LOAD;
        r.item.xs = COORD'(xs);
        r.item.ys = COORD'(ys);
        r.item.xe = COORD'(xe);
        r.item.ye = COORD'(ye);
        r.typed   = 1'b0;
        r.want    = '0;
        return r;
    endfunction

    function automatic t_plan_row step_row();
        t_plan_row r;
        r.item    = '0;
        r.item.op = OP_STEP;
        r.typed   = 1'b0;
        r.want    = '0;
        return r;
    endfunction

    function automatic t_plan_row typed_step(input int idx, input bit we,
                                             input logic [COLOR_BITS-1:0] color,
                                             input bit last);
        t_plan_row r;
        r = step_row();
        r.typed      = 1'b1;
        r.want.index = INDEX_BITS'(idx);
        r.want.we    = we;
        r.want.color = color;
        r.want.last  = last;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Pixel sink: ready idles at random except while calm is set.
    // ------------------------------------------------------------------------
    initial begin
        pixel_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            pixel_ch.ready <= calm || ($urandom_range(99) >= 36);
        end
    end

    // Every pixel beat is matched against the oldest expected one.
    always @(negedge i_clk) begin
        t_pixel want;
        if (i_rst_n === 1'b1 && pixel_ch.valid === 1'b1 && pixel_ch.ready === 1'b1) begin
            if (pending_pixels.size() == 0) begin
                flag_error($sformatf("pixel beat with none expected, index %0d",
                                     pixel_ch.pixel_index));
            end else begin
                want = pending_pixels.pop_front();
                if (pixel_ch.pixel_index !== want.index)
                    flag_error($sformatf("pixel_index %0d, expected %0d",
                                         pixel_ch.pixel_index, want.index));
                if (pixel_ch.write_enable !== want.we)
                    flag_error($sformatf("write_enable %b, expected %b (index %0d)",
                                         pixel_ch.write_enable, want.we, want.index));
                if (pixel_ch.rgba_color !== want.color)
                    flag_error($sformatf("rgba_color %h, expected %h",
                                         pixel_ch.rgba_color, want.color));
                if (pixel_ch.last_step !== want.last)
                    flag_error($sformatf("last_step %b, expected %b (index %0d)",
                                         pixel_ch.last_step, want.last, want.index));
            end
        end
    end

    // A hung handshake ends the run here.
    initial begin
        while (cycle_count <= CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        t_plan_row plan[$];
        bit        useful;
        int        k;

        item_ch.valid   <= 1'b0;
        item_ch.op      <= OP_LOAD;
        item_ch.x_start <= '0;
        item_ch.y_start <= '0;
        item_ch.x_end   <= '0;
        item_ch.y_end   <= '0;
        cfg_we          <= 1'b0;
        cfg_addr        <= CFG_TEX_WIDTH;
        cfg_data        <= '0;
        i_rst_n         <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table, run at the reset texture size of 640 x 480.
        // A step straight out of reset finds no line.
        plan.push_back(step_row());
        // A zero-length line stays inactive, so the step after it is dropped.
        plan.push_back(load_row(0, 0, 0, 0));
        plan.push_back(step_row());
        // Shallow X-major line: the first pixel lands on index 0 and is
        // not written; the walk ends with last_step, then a step is dropped.
        plan.push_back(load_row(0, 0, 3, 1));
        plan.push_back(typed_step(0, 1'b0, COLOR_X_MAJOR, 1'b0));
        plan.push_back(step_row());
        plan.push_back(step_row());
        plan.push_back(step_row());
        // Vertical line loaded bottom-up; the endpoints get swapped.
        plan.push_back(load_row(5, 2, 5, 0));
        plan.push_back(typed_step(5, 1'b1, COLOR_Y_MAJOR, 1'b0));
        plan.push_back(typed_step(5, 1'b1, COLOR_Y_MAJOR, 1'b1));
        // Equal deltas pick the X axis.
        plan.push_back(load_row(0, 0, 2, 2));
        plan.push_back(typed_step(0, 1'b0, COLOR_X_MAJOR, 1'b0));
        plan.push_back(typed_step(641, 1'b1, COLOR_X_MAJOR, 1'b1));
        // Negative coordinates clamp the index to zero.
        plan.push_back(load_row(-3, -3, -1, 10));
        plan.push_back(typed_step(0, 1'b0, COLOR_Y_MAJOR, 1'b0));
        // A new load replaces the line in progress; extreme endpoints.
        plan.push_back(load_row(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX));
        plan.push_back(typed_step(0, 1'b0, COLOR_X_MAJOR, 1'b0));
        plan.push_back(step_row());
        // Full-span diagonal the other way: slope of minus one.
        plan.push_back(load_row(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX));
        plan.push_back(typed_step(0, 1'b0, COLOR_X_MAJOR, 1'b0));
        // Across the far corner of the texture: last in-range index, then
        // the first one that falls outside.
        plan.push_back(load_row(639, 480, 641, 480));
        plan.push_back(step_row());
        plan.push_back(step_row());
        foreach (plan[k])
            send_item(plan[k].item, plan[k].typed, plan[k].want, useful);

        // Random traffic at the reset size, with a stretch where nobody
        // idles and a full stop mid-phase until all pixels are back.
        run_lines(120);
        calm = 1'b1;
        run_lines(100);
        calm = 1'b0;
        drain_pipeline();
        run_lines(80);

        // Smallest texture, largest legal one, a zero-size one, the largest
        // the register holds, a single row, then two random sizes.
        set_texture(13'd1, 13'd1);
        run_lines(70);
        set_texture(13'd4096, 13'd4096);
        run_lines(140);
        set_texture(13'd0, 13'd300);
        run_lines(50);
        set_texture(13'd8191, 13'd8191);
        run_lines(70);
        set_texture(13'd4096, 13'd1);
        run_lines(50);
        for (k = 0; k < 2; k++) begin
            set_texture(REG_BITS'($urandom_range(8191)), REG_BITS'($urandom_range(8191)));
            run_lines(60);
        end

        drain_pipeline();
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
